>>> sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Table geometry and header size.
  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 12;
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  // Addresses and sizes are 32 bits wide, as are the request fields.
  localparam int DATA_W = 32;
  localparam logic [DATA_W-1:0] HDR = DATA_W'(HEADER_BYTES);

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 136;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_RESIZE = 2'd2,
    ACT_CALLOC = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_ALLOC_CHK,
    S_SCAN,
    S_FIND_DONE,
    S_FIT_DONE,
    S_FREE_OLD,
    S_DONE
  } state_t;

  // Search token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic              act;   // token present
    logic              find;  // 1: address lookup, 0: first-fit search
    logic [DATA_W-1:0] key;   // payload address or rounded size
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] pay;
    logic [DATA_W-1:0] size;
  } tok_t;

  // Table write broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic              append;  // also load payload address and size
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] pay;
    logic [DATA_W-1:0] size;
    logic              free;
  } wr_t;

endpackage

>>> sv/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap block allocator built on a row of table cells.
// ----------------------------------------------------------------------------
// Allocate, free and in-place resize each run one search of the cell row; a
// zeroed allocate adds a multiply step first, and a moving resize runs two
// searches, a lookup and then a first-fit search.
// One request at a time: the next request can be taken in the same cycle as
// the result appears, once the output register is free to take the result,
// and the walk of the search token down the MAX_BLOCKS cells sets the pace.
// Zero-address frees and zero-size allocations finish without a search. Reset
// (rst_n low, synchronous) empties the table and clears both heap registers;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream. tdata from bit 0 up: action[1:0], request_bytes[33:2],
  // element_count[65:34], block_address[97:66], zero pad [103:98].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [ffba_pkg::IN_TDATA_W-1:0] in_tdata,
  // Result stream. tdata from bit 0 up: status[1:0], payload_address[33:2],
  // copy_source[65:34], copy_bytes[97:66], clear_bytes[129:98], pad [135:130].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffba_pkg::DATA_W-1:0]    cfg_wdata
);
  import ffba_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0] heap_base_r;
  logic [DATA_W-1:0] heap_limit_r;

  // Control state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] last_end_r, last_end_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Request fields held for the duration of the request.
  action_t           act_r;
  logic [DATA_W-1:0] req_r, cnt_r, addr_r;

  // Working registers.
  logic [2*DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] size_r, size_nxt;
  logic [DATA_W-1:0] need_r, need_nxt;
  logic              find_r, find_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [DATA_W-1:0] hit_pay_r, hit_pay_nxt;
  logic [DATA_W-1:0] hit_size_r, hit_size_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [DATA_W-1:0] ksize_r, ksize_nxt;
  logic              mv_r, mv_nxt;

  // Result being built, and the output register.
  status_t           rs_status_r, rs_status_nxt;
  logic [DATA_W-1:0] rs_pay_r, rs_pay_nxt;
  logic [DATA_W-1:0] rs_csrc_r, rs_csrc_nxt;
  logic [DATA_W-1:0] rs_cbytes_r, rs_cbytes_nxt;
  logic [DATA_W-1:0] rs_clr_r, rs_clr_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Token row and table write.
  tok_t tok_chain [0:MAX_BLOCKS];
  tok_t launch_tok;
  tok_t tail;
  wr_t  wr;

  // Combinational helpers.
  logic              in_fire;
  logic [DATA_W:0]   need_wide;
  logic [DATA_W-1:0] brk;
  logic [DATA_W+1:0] new_brk;
  logic              out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign tail       = tok_chain[MAX_BLOCKS];

  // Size rounded up to a multiple of 8; bit 32 set means it no longer fits.
  assign need_wide = ({1'b0, size_r} + (DATA_W+1)'(7)) & ~((DATA_W+1)'(7));
  // The break is the heap base while the table is empty, else the end of
  // the last block, which is tracked here rather than read from the row.
  assign brk       = (count_r == '0) ? heap_base_r : last_end_r;
  assign new_brk   = {2'b00, brk} + (DATA_W+2)'(HEADER_BYTES) + {2'b00, need_r};

  // --------------------------------------------------------------------------
  // Configuration writes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= '0;
      heap_limit_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEAP_BASE:  heap_base_r  <= cfg_wdata;
        REG_HEAP_LIMIT: heap_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Row of table cells. A token enters cell 0 and moves one cell per cycle;
  // the first matching cell stamps its index, payload address and size.
  // --------------------------------------------------------------------------
  assign tok_chain[0] = launch_tok;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffba_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (CNT_W'(g)),
      .count    (count_r),
      .tok_in   (tok_chain[g]),
      .tok_out  (tok_chain[g+1]),
      .wr       (wr)
    );
  end

  // --------------------------------------------------------------------------
  // Next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (act_r)
          ACT_ALLOC:  state_nxt = S_ALLOC_CHK;
          ACT_CALLOC: state_nxt = S_MUL;
          ACT_FREE:   state_nxt = (addr_r == '0) ? S_DONE : S_SCAN;
          ACT_RESIZE: state_nxt = (addr_r == '0) ? S_ALLOC_CHK : S_SCAN;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_MUL: state_nxt = S_ALLOC_CHK;
      S_ALLOC_CHK: begin
        if (size_r == '0 || heap_base_r == '0 || need_wide[DATA_W]) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (tail.act) state_nxt = find_r ? S_FIND_DONE : S_FIT_DONE;
      end
      S_FIND_DONE: begin
        if (hit_r && act_r == ACT_RESIZE && req_r != '0 && hit_size_r < req_r) begin
          state_nxt = S_ALLOC_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIT_DONE: begin
        state_nxt = S_DONE;
        if (mv_r && (hit_r || (count_r < CNT_W'(MAX_BLOCKS) && new_brk[DATA_W+1:DATA_W] == '0
                                && new_brk[DATA_W-1:0] <= heap_limit_r))) begin
          state_nxt = S_FREE_OLD;
        end
      end
      S_FREE_OLD: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs and datapath next values.
  // --------------------------------------------------------------------------
  always_comb begin
    launch_tok    = '0;
    wr            = '0;
    count_nxt     = count_r;
    last_end_nxt  = last_end_r;
    prod_nxt      = prod_r;
    size_nxt      = size_r;
    need_nxt      = need_r;
    find_nxt      = find_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_pay_nxt   = hit_pay_r;
    hit_size_nxt  = hit_size_r;
    k_nxt         = k_r;
    ksize_nxt     = ksize_r;
    mv_nxt        = mv_r;
    rs_status_nxt = rs_status_r;
    rs_pay_nxt    = rs_pay_r;
    rs_csrc_nxt   = rs_csrc_r;
    rs_cbytes_nxt = rs_cbytes_r;
    rs_clr_nxt    = rs_clr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: ;
      S_DECODE: begin
        rs_status_nxt = ST_OK;
        rs_pay_nxt    = '0;
        rs_csrc_nxt   = '0;
        rs_cbytes_nxt = '0;
        rs_clr_nxt    = '0;
        mv_nxt        = 1'b0;
        size_nxt      = req_r;
        prod_nxt      = (2*DATA_W)'(cnt_r) * (2*DATA_W)'(req_r);
        if ((act_r == ACT_FREE || act_r == ACT_RESIZE) && addr_r != '0) begin
          launch_tok.act  = 1'b1;
          launch_tok.find = 1'b1;
          launch_tok.key  = addr_r;
          find_nxt        = 1'b1;
        end else if (act_r == ACT_FREE) begin
          rs_status_nxt = ST_NONE;
        end
      end
      S_MUL: begin
        // Saturate the element total to all ones on overflow.
        size_nxt = (prod_r[2*DATA_W-1:DATA_W] != '0) ? '1 : prod_r[DATA_W-1:0];
      end
      S_ALLOC_CHK: begin
        need_nxt = need_wide[DATA_W-1:0];
        if (size_r == '0) begin
          rs_status_nxt = ST_NONE;
        end else if (heap_base_r == '0 || need_wide[DATA_W]) begin
          rs_status_nxt = ST_OOM;
        end else begin
          launch_tok.act  = 1'b1;
          launch_tok.find = 1'b0;
          launch_tok.key  = need_wide[DATA_W-1:0];
          find_nxt        = 1'b0;
        end
      end
      S_SCAN: begin
        if (tail.act) begin
          hit_nxt      = tail.hit;
          hit_idx_nxt  = tail.idx;
          hit_pay_nxt  = tail.pay;
          hit_size_nxt = tail.size;
        end
      end
      S_FIND_DONE: begin
        k_nxt     = hit_idx_r;
        ksize_nxt = hit_size_r;
        if (!hit_r) begin
          rs_status_nxt = ST_UNKNOWN;
        end else if (act_r == ACT_FREE || req_r == '0) begin
          // Free, or resize to zero: mark the block free.
          wr.en   = 1'b1;
          wr.idx  = hit_idx_r;
          wr.free = 1'b1;
        end else if (hit_size_r >= req_r) begin
          rs_pay_nxt = addr_r;
        end else begin
          // Block too small: allocate elsewhere, then release the old one.
          mv_nxt   = 1'b1;
          size_nxt = req_r;
        end
      end
      S_FIT_DONE: begin
        if (hit_r) begin
          wr.en      = 1'b1;
          wr.idx     = hit_idx_r;
          wr.free    = 1'b0;
          rs_pay_nxt = hit_pay_r;
          if (act_r == ACT_CALLOC) rs_clr_nxt = size_r;
        end else if (count_r >= CNT_W'(MAX_BLOCKS) || new_brk[DATA_W+1:DATA_W] != '0
                     || new_brk[DATA_W-1:0] > heap_limit_r) begin
          rs_status_nxt = ST_OOM;
        end else begin
          wr.en        = 1'b1;
          wr.append    = 1'b1;
          wr.idx       = count_r[IDX_W-1:0];
          wr.pay       = brk + HDR;
          wr.size      = need_r;
          wr.free      = 1'b0;
          count_nxt    = count_r + CNT_W'(1);
          last_end_nxt = new_brk[DATA_W-1:0];
          rs_pay_nxt   = brk + HDR;
          if (act_r == ACT_CALLOC) rs_clr_nxt = size_r;
        end
      end
      S_FREE_OLD: begin
        wr.en         = 1'b1;
        wr.idx        = k_r;
        wr.free       = 1'b1;
        rs_csrc_nxt   = addr_r;
        rs_cbytes_nxt = ksize_r;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, rs_clr_r, rs_cbytes_r, rs_csrc_r, rs_pay_r, rs_status_r};
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= action_t'(in_tdata[1:0]);
      req_r  <= in_tdata[33:2];
      cnt_r  <= in_tdata[65:34];
      addr_r <= in_tdata[97:66];
    end
    last_end_r  <= last_end_nxt;
    prod_r      <= prod_nxt;
    size_r      <= size_nxt;
    need_r      <= need_nxt;
    find_r      <= find_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_pay_r   <= hit_pay_nxt;
    hit_size_r  <= hit_size_nxt;
    k_r         <= k_nxt;
    ksize_r     <= ksize_nxt;
    mv_r        <= mv_nxt;
    rs_status_r <= rs_status_nxt;
    rs_pay_r    <= rs_pay_nxt;
    rs_csrc_r   <= rs_csrc_nxt;
    rs_cbytes_r <= rs_cbytes_nxt;
    rs_clr_r    <= rs_clr_nxt;
    out_data_r  <= out_data_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // A search token only leaves the row while the controller waits for it.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.act |-> state_r == S_SCAN)
    else $error("search token left the cell row outside of a scan");

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCKS))
    else $error("entry count exceeds table size");

  // Every append grows the table by exactly one entry.
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en && wr.append |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("append did not advance the entry count");

  // A failed request never hands out a payload address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[1:0] != ST_OK |-> out_data_r[33:2] == '0)
    else $error("failed request returned a payload address");

endmodule

>>> sv/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One table entry plus one stage of the search token pipeline.
// ----------------------------------------------------------------------------
module ffba_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ffba_pkg::CNT_W-1:0] cell_idx,
  input  logic [ffba_pkg::CNT_W-1:0] count,
  input  ffba_pkg::tok_t        tok_in,
  output ffba_pkg::tok_t        tok_out,
  input  ffba_pkg::wr_t         wr
);
  import ffba_pkg::*;

  logic [DATA_W-1:0] pay_r;
  logic [DATA_W-1:0] size_r;
  logic              free_r;
  logic              act_r;
  tok_t              dat_r;
  tok_t              dat_nxt;
  logic              in_use;
  logic              match;

  // Entries are only meaningful below the fill count.
  assign in_use = (cell_idx < count);
  assign match  = in_use && (tok_in.find ? (pay_r == tok_in.key)
                                         : (free_r && (size_r >= tok_in.key)));

  always_comb begin
    dat_nxt = tok_in;
    if (tok_in.act && !tok_in.hit && match) begin
      dat_nxt.hit  = 1'b1;
      dat_nxt.idx  = cell_idx[IDX_W-1:0];
      dat_nxt.pay  = pay_r;
      dat_nxt.size = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= tok_in.act;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
    if (wr.en && (wr.idx == cell_idx[IDX_W-1:0])) begin
      free_r <= wr.free;
      if (wr.append) begin
        pay_r  <= wr.pay;
        size_r <= wr.size;
      end
    end
  end

  always_comb begin
    tok_out     = dat_r;
    tok_out.act = act_r;
  end

endmodule

>>> tb/sv/allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// allocator_checker
// Watches the request, result and register ports of the first-fit block
// allocator, keeps its own copy of the block table, and compares every
// result with the outcome it worked out when the request was accepted.
// ----------------------------------------------------------------------------
module allocator_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ffba_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ffba_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffba_pkg::DATA_W-1:0]     cfg_wdata,
  output int                              fail_count,
  output int                              open_count
);
  import ffba_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] payload_address;
    logic [31:0] copy_source;
    logic [31:0] copy_bytes;
    logic [31:0] clear_bytes;
  } alloc_result_t;

  logic [DATA_W-1:0] blk_start [MAX_BLOCKS];
  logic [DATA_W-1:0] blk_size  [MAX_BLOCKS];
  logic              blk_free  [MAX_BLOCKS];
  int                blk_count;
  logic [DATA_W-1:0] heap_base_q;
  logic [DATA_W-1:0] heap_limit_q;
  alloc_result_t     pending_results [$];
  int                errors = 0;

  assign fail_count = errors;

  // First fit over the table, else append at the break.
  function automatic status_t place_block(input logic [63:0] bytes,
                                          output logic [DATA_W-1:0] pay);
    logic [63:0] need;
    logic [63:0] brk;
    logic [63:0] next_brk;
    pay = '0;
    if (bytes == 0) return ST_NONE;
    if (heap_base_q == 0) return ST_OOM;
    need = (bytes + 64'd7) & ~64'd7;
    if (need > 64'hFFFF_FFFF) return ST_OOM;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= need) begin
        blk_free[i] = 1'b0;
        pay = blk_start[i] + HDR;
        return ST_OK;
      end
    end
    if (blk_count >= MAX_BLOCKS) return ST_OOM;
    if (blk_count == 0) begin
      brk = 64'(heap_base_q);
    end else begin
      brk = (64'(blk_start[blk_count-1]) + 64'(HDR) + 64'(blk_size[blk_count-1]))
            & 64'hFFFF_FFFF;
    end
    next_brk = brk + 64'(HDR) + need;
    if (next_brk > 64'hFFFF_FFFF || next_brk > 64'(heap_limit_q)) return ST_OOM;
    blk_start[blk_count] = brk[31:0];
    blk_size[blk_count]  = need[31:0];
    blk_free[blk_count]  = 1'b0;
    blk_count++;
    pay = brk[31:0] + HDR;
    return ST_OK;
  endfunction

  // Index of the block that owns a payload address, free or not; -1 if none.
  function automatic int lookup_block(input logic [DATA_W-1:0] addr);
    for (int i = 0; i < blk_count; i++)
      if (blk_start[i] + HDR == addr) return i;
    return -1;
  endfunction

  function automatic alloc_result_t predict_result(input action_t act,
                                                   input logic [31:0] req,
                                                   input logic [31:0] cnt,
                                                   input logic [31:0] addr);
    alloc_result_t r;
    logic [31:0]   pay;
    logic [63:0]   total;
    int            k;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_ALLOC: begin
        r.status = place_block(64'(req), pay);
        r.payload_address = pay;
      end
      ACT_FREE: begin
        if (addr == 0) begin
          r.status = ST_NONE;
        end else begin
          k = lookup_block(addr);
          if (k < 0) r.status = ST_UNKNOWN;
          else blk_free[k] = 1'b1;
        end
      end
      ACT_RESIZE: begin
        if (addr == 0) begin
          r.status = place_block(64'(req), pay);
          r.payload_address = pay;
        end else begin
          k = lookup_block(addr);
          if (k < 0) begin
            r.status = ST_UNKNOWN;
          end else if (req == 0) begin
            blk_free[k] = 1'b1;
          end else if (blk_size[k] >= req) begin
            r.payload_address = addr;
          end else begin
            r.status = place_block(64'(req), pay);
            r.payload_address = pay;
            if (r.status == ST_OK) begin
              r.copy_source = addr;
              r.copy_bytes  = blk_size[k];
              blk_free[k]   = 1'b1;
            end
          end
        end
      end
      default: begin
        // Zeroed allocate: the byte count saturates instead of wrapping.
        total = 64'(cnt) * 64'(req);
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        r.status = place_block(total, pay);
        r.payload_address = pay;
        if (r.status == ST_OK) r.clear_bytes = total[31:0];
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      blk_count    = 0;
      heap_base_q  = '0;
      heap_limit_q = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_BASE) heap_base_q = cfg_wdata;
        else if (cfg_index == REG_HEAP_LIMIT) heap_limit_q = cfg_wdata;
      end
      // Results are retired before a request taken on the same edge is added.
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_tdata[1:0]));
          check_field("payload_address", want.payload_address, out_tdata[33:2]);
          check_field("copy_source", want.copy_source, out_tdata[65:34]);
          check_field("copy_bytes", want.copy_bytes, out_tdata[97:66]);
          check_field("clear_bytes", want.clear_bytes, out_tdata[129:98]);
        end
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(predict_result(action_t'(in_tdata[1:0]),
                                                 in_tdata[33:2], in_tdata[65:34],
                                                 in_tdata[97:66]));
      end
    end
    open_count <= pending_results.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives requests and heap register settings into the first-fit block
// allocator and gives the verdict; the checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import ffba_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = REG_HEAP_BASE;
  logic [DATA_W-1:0]      cfg_wdata  = '0;
  int                     fail_count;
  int                     open_count;

  // Percentages of cycles in which the request side holds back and the
  // result side refuses a result. Both drop to zero for one long stretch.
  int in_idle_pct   = 19;
  int out_stall_pct = 19;

  // Payload addresses the block has handed out, gathered from the result
  // stream so that frees and resizes can aim at real blocks. Appends always
  // land above every earlier block, so a new highest address means that the
  // table grew by one entry.
  logic [31:0] live_addrs [$];
  logic [31:0] top_addr     = '0;
  logic [31:0] last_payload = '0;
  int          block_total  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_block_allocator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  allocator_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  // The result side accepts at random, decided fresh at every edge.
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= out_stall_pct);
  end

  // Sampled on the falling edge, where valid and ready are settled; a result
  // that is valid and ready here is taken at the next rising edge.
  always @(negedge clk) begin
    logic [31:0] pay;
    bit          known;
    if (rst_n && out_tvalid && out_tready) begin
      pay = out_tdata[33:2];
      last_payload = pay;
      if (status_t'(out_tdata[1:0]) == ST_OK && pay != 0) begin
        known = 1'b0;
        foreach (live_addrs[i]) if (live_addrs[i] == pay) known = 1'b1;
        if (!known) live_addrs.push_back(pay);
        if (pay > top_addr) begin
          top_addr = pay;
          block_total++;
        end
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] request_word(input action_t act,
                                                         input logic [31:0] req,
                                                         input logic [31:0] cnt,
                                                         input logic [31:0] addr);
    return {6'b0, addr, cnt, req, act};
  endfunction

  // Presents one request and returns at the edge where it is taken. Valid is
  // left high, so a following request goes out back to back; whoever stops
  // sending lowers it.
  task automatic send_req(input logic [IN_TDATA_W-1:0] word);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // Waits until every request taken so far has had its result checked.
  task automatic wait_drained();
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic send_and_wait(input logic [IN_TDATA_W-1:0] word);
    send_req(word);
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  // Both heap registers are written on consecutive edges while the block is
  // idle, so that no request sees half of a new setting.
  task automatic set_heap(input logic [31:0] base, input logic [31:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEAP_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= REG_HEAP_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random requests. Most frees and resizes name a block that exists; the
  // rest use zero or an arbitrary address. Sizes are mostly modest so that
  // the heap fills up against its limit and first fit gets to reuse blocks,
  // with some huge ones that can only fail.
  task automatic run_random(input int n);
    action_t     act;
    logic [31:0] req;
    logic [31:0] cnt;
    logic [31:0] addr;
    int          r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        addr = '0;
      end else if (r < 80 && live_addrs.size() != 0) begin
        addr = live_addrs[$urandom_range(live_addrs.size() - 1)];
      end else if (r < 90 && live_addrs.size() != 0) begin
        addr = live_addrs[$urandom_range(live_addrs.size() - 1)] + 32'd8;
      end else begin
        addr = $urandom();
      end
      r = $urandom_range(99);
      if (r < 5) req = '0;
      else if (r < 30) req = $urandom_range(64, 1);
      else if (r < 90) req = $urandom_range(1024, 65);
      else if (r < 95) req = $urandom();
      else req = 32'hFFFF_FFFF - $urandom_range(15);
      cnt = $urandom();
      r = $urandom_range(99);
      if (r < 35) begin
        act = ACT_ALLOC;
      end else if (r < 62) begin
        act = ACT_FREE;
      end else if (r < 84) begin
        act = ACT_RESIZE;
      end else begin
        act = ACT_CALLOC;
        r = $urandom_range(9);
        if (r == 0) begin
          cnt = '0;
        end else if (r == 1) begin
          cnt = $urandom();
          req = $urandom();
        end else begin
          cnt = $urandom_range(16, 1);
          req = $urandom_range(64, 1);
        end
      end
      send_req(request_word(act, req, cnt, addr));
    end
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] brk;
    logic [31:0] need;
    int          tries;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Heap unavailable: every allocation fails, frees find nothing, and a
    // zero-size request or a free of address zero does nothing at all.
    set_heap(32'h0000_0000, 32'hFFFF_FFFF);
    send_and_wait(request_word(ACT_ALLOC, 32'd16, 32'd0, 32'd0));
    send_and_wait(request_word(ACT_ALLOC, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_and_wait(request_word(ACT_CALLOC, 32'd4, 32'd4, 32'd0));
    send_and_wait(request_word(ACT_FREE, 32'd0, 32'd0, 32'd0));
    send_and_wait(request_word(ACT_FREE, 32'd8, 32'd0, 32'hFFFF_FFFF));
    send_and_wait(request_word(ACT_RESIZE, 32'd8, 32'd0, 32'd0));

    // Base at the very top: the first block would run past the address
    // space, whether the limit is zero or at its maximum.
    set_heap(32'hFFFF_FFFF, 32'h0000_0000);
    send_and_wait(request_word(ACT_ALLOC, 32'd8, 32'd0, 32'd0));
    set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_and_wait(request_word(ACT_ALLOC, 32'd8, 32'd0, 32'd0));

    // A small working heap of 8 KB.
    set_heap(32'h0000_1000, 32'h0000_3000);
    send_and_wait(request_word(ACT_ALLOC, 32'd1, 32'd0, 32'd0));
    a0 = last_payload;
    // Rounding up past 32 bits, then a size that rounds fine but cannot fit.
    send_and_wait(request_word(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0));
    send_and_wait(request_word(ACT_ALLOC, 32'hFFFF_FFF8, 32'd0, 32'd0));
    send_and_wait(request_word(ACT_CALLOC, 32'd5, 32'd3, 32'd0));
    a1 = last_payload;
    send_and_wait(request_word(ACT_CALLOC, 32'd9, 32'd0, 32'd0));
    // Count times size overflows and saturates, which then cannot be met.
    send_and_wait(request_word(ACT_CALLOC, 32'h0001_0000, 32'h0001_0000, 32'd0));
    // Freeing the same block twice is accepted; the next request reuses it.
    send_and_wait(request_word(ACT_FREE, 32'd0, 32'd0, a0));
    send_and_wait(request_word(ACT_FREE, 32'd0, 32'd0, a0));
    send_and_wait(request_word(ACT_ALLOC, 32'd8, 32'd0, 32'd0));
    // Resize that still fits, one that has to move, and one down to zero.
    send_and_wait(request_word(ACT_RESIZE, 32'd16, 32'd0, a1));
    send_and_wait(request_word(ACT_RESIZE, 32'd100, 32'd0, a1));
    a2 = last_payload;
    send_and_wait(request_word(ACT_RESIZE, 32'd0, 32'd0, a2));
    send_and_wait(request_word(ACT_RESIZE, 32'd8, 32'd0, 32'h1234_5678));
    send_and_wait(request_word(ACT_RESIZE, 32'd24, 32'd0, 32'd0));
    send_and_wait(request_word(ACT_FREE, 32'd0, 32'd0, a2 + 32'd8));

    run_random(400);

    // More room, and first a long stretch with no idling on either side.
    set_heap(32'h0000_1000, 32'h0000_5000);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    run_random(200);
    in_idle_pct   = 19;
    out_stall_pct = 19;
    run_random(200);

    // Heap switched off while blocks exist: even reuse must fail.
    set_heap(32'h0000_0000, 32'h0000_5000);
    run_random(60);

    // A new base while blocks exist; the break stays at the last block.
    set_heap(32'h8000_0000, 32'h0000_5000);
    run_random(450);

    // Open the whole address space. Appends too large for any free block
    // bring the table to two short of full, one huge block then ends just
    // below the top, the next append runs past 32 bits, a mid-sized one
    // takes the last slot, and after that the table is full.
    set_heap(32'h8000_0000, 32'hFFFF_FFFF);
    tries = 0;
    while (block_total < MAX_BLOCKS - 2 && tries < MAX_BLOCKS) begin
      send_and_wait(request_word(ACT_ALLOC, 32'h0002_0000, $urandom(), $urandom()));
      tries++;
    end
    brk  = top_addr + 32'h0002_0000;
    need = (32'hFFF0_0000 - brk - 32'(HEADER_BYTES)) & ~32'h7;
    send_and_wait(request_word(ACT_ALLOC, need, 32'd0, 32'd0));
    send_and_wait(request_word(ACT_ALLOC, 32'h0020_0000, 32'd0, 32'd0));
    send_and_wait(request_word(ACT_ALLOC, 32'h0008_0000, 32'd0, 32'd0));
    send_and_wait(request_word(ACT_ALLOC, 32'h0004_0000, 32'd0, 32'd0));
    run_random(120);

    // A moving resize is the slowest request; give any stray result time
    // to show up before the verdict.
    repeat (2 * MAX_BLOCKS + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS first_fit_block_allocator_top");
    end else begin
      $display("FAIL first_fit_block_allocator_top");
    end
    $finish;
  end

  // Several times the slowest correct run, even with every request a moving
  // resize.
  initial begin
    #(12_000_000);
    $display("FAIL first_fit_block_allocator_top");
    $finish;
  end

endmodule

>>> first_fit_block_allocator_top.f
sv/ffba_pkg.sv
sv/ffba_cell.sv
sv/first_fit_block_allocator_top.sv
tb/sv/allocator_checker.sv
tb/sv/tb_top.sv
